FILE: rtl/core/e2q_pkg.sv
// Package for the Euler-angle to quaternion converter: payload word types,
// default parameters and the quarter-wave sine table function. No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int ROM_BITS_DEF  = 10;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_ONE       = 16384;

  typedef struct packed {
    logic [15:0] heading_angle;
    logic [15:0] pitch_angle;
    logic [15:0] bank_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  // Q2.62 multiply, keeping bits [125:62] of the full product.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    begin
      p = {64'd0, a} * {64'd0, b};
      mul_q62 = p[125:62];
    end
  endfunction

  // Sine of k quarter-turn steps out of 2^rom_bits, rounded to frac_bits and
  // capped at 1.0. Only evaluated at elaboration to build a constant table.
  function automatic logic [31:0] sine_entry(input int k, input int rom_bits,
                                             input int frac_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    int n;
    begin
      x    = mul_q62(64'h6487ED5110B4611A, 64'(k) << (62 - rom_bits));
      x2   = mul_q62(x, x);
      sum  = x;
      term = x;
      for (n = 1; n < 61; n += 2) begin
        if (term != 64'd0) begin
          term = mul_q62(term, x2) / 64'((n + 1) * (n + 2));
          if (((n >> 1) & 1) == 0) sum = sum - term;
          else sum = sum + term;
        end
      end
      r = (sum + (64'd1 << (61 - frac_bits))) >> (62 - frac_bits);
      if (r > (64'd1 << frac_bits)) r = 64'd1 << frac_bits;
      sine_entry = r[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/e2q_sincos.sv
// Half-angle sine and cosine of one binary angle, one registered stage.
// Depends on e2q_pkg for the sine table function.
`timescale 1ns / 1ps
module e2q_sincos #(
  parameter int ROM_BITS  = e2q_pkg::ROM_BITS_DEF,
  parameter int FRAC_BITS = e2q_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [15:0]                 angle,
  output logic signed [FRAC_BITS+1:0] sin_val,
  output logic signed [FRAC_BITS+1:0] cos_val
);
  import e2q_pkg::*;

  localparam int SIZE  = 1 << ROM_BITS;
  localparam int SHIFT = 15 - ROM_BITS;
  localparam int PW    = ROM_BITS + 2;
  localparam int SW    = FRAC_BITS + 2;

  logic [FRAC_BITS:0] rom [0:SIZE];

  genvar g;
  generate
    for (g = 0; g <= SIZE; g++) begin : g_rom
      localparam logic [31:0] ENTRY = sine_entry(g, ROM_BITS, FRAC_BITS);
      assign rom[g] = ENTRY[FRAC_BITS:0];
    end
  endgenerate

  logic [16:0]         rounded;
  logic [PW-1:0]       phase;
  logic [1:0]          quad;
  logic [ROM_BITS-1:0] k;
  logic [ROM_BITS:0]   k_up;
  logic [ROM_BITS:0]   k_dn;
  logic signed [SW-1:0] a_pos;
  logic signed [SW-1:0] b_pos;

  always_comb begin
    rounded = {1'b0, angle} + 17'(1 << (SHIFT - 1));
    phase   = rounded[SHIFT +: PW];
    quad    = phase[PW-1 -: 2];
    k       = phase[ROM_BITS-1:0];
    k_up    = {1'b0, k};
    k_dn    = (ROM_BITS + 1)'(SIZE) - k_up;
    a_pos   = SW'(rom[k_up]);
    b_pos   = SW'(rom[k_dn]);
  end

  always_ff @(posedge clk) begin
    unique case (quad)
      2'd0: begin sin_val <= a_pos;  cos_val <= b_pos;  end
      2'd1: begin sin_val <= b_pos;  cos_val <= -a_pos; end
      2'd2: begin sin_val <= -a_pos; cos_val <= -b_pos; end
      default: begin sin_val <= -b_pos; cos_val <= a_pos; end
    endcase
  end

endmodule

FILE: rtl/core/euler_to_quaternion.sv
// Top level of the Euler-angle (heading, pitch, bank) to quaternion converter.
// Depends on e2q_pkg and instantiates three e2q_sincos units.
`timescale 1ns / 1ps
// A new word of three binary angles is taken on every clock that start is
// high; busy is always low, so the block runs at one word per clock. Each
// word gives exactly one quaternion word at the end of stage 4, shown for one
// cycle with done high. The receiver cannot hold results off, and none is
// needed: the pipeline never stalls. Stage 1 looks up the half-angle sines
// and cosines, stage 2 forms the four pair products rounded back to Q1.14,
// stage 3 multiplies each by both bank factors, and stage 4 adds or
// subtracts the two terms of each component, rounds, saturates to +-1.0
// and applies the direction register (1 gives the conjugate). Write
// direction only while no word is in flight.
module euler_to_quaternion #(
  parameter int ROM_BITS  = e2q_pkg::ROM_BITS_DEF,
  parameter int FRAC_BITS = e2q_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  e2q_pkg::angles_t angles,
  input  logic            cfg_we,
  input  logic            cfg_data,
  output logic            done,
  output e2q_pkg::quat_t  quat
);
  import e2q_pkg::*;

  localparam int SW = FRAC_BITS + 2;   // sine/cosine width
  localparam int PW = 2 * SW;          // product width
  localparam int RSH = 2 * FRAC_BITS - 14;

  logic       direction;
  logic [3:0] valid;

  logic signed [SW-1:0] sh, ch, sp, cp, sb, cb;

  e2q_sincos #(.ROM_BITS(ROM_BITS), .FRAC_BITS(FRAC_BITS)) u_head (
    .clk(clk), .angle(angles.heading_angle), .sin_val(sh), .cos_val(ch));
  e2q_sincos #(.ROM_BITS(ROM_BITS), .FRAC_BITS(FRAC_BITS)) u_pitch (
    .clk(clk), .angle(angles.pitch_angle), .sin_val(sp), .cos_val(cp));
  e2q_sincos #(.ROM_BITS(ROM_BITS), .FRAC_BITS(FRAC_BITS)) u_bank (
    .clk(clk), .angle(angles.bank_angle), .sin_val(sb), .cos_val(cb));

  // Round-half-away-from-zero right shift of a signed value.
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                              input int sh_amt);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    begin
      m = v[PW-1] ? PW'(-v) : PW'(v);
      r = (m + (PW'(1) << (sh_amt - 1))) >> sh_amt;
      rnd = v[PW-1] ? -$signed(r) : $signed(r);
    end
  endfunction

  // Stage 2: pair products rounded to FRAC_BITS; third factors carried.
  // Operands are sign-extended to the product width before multiplying.
  logic signed [SW-1:0] p_ccc, p_sss, p_csc, p_scs, p_scc, p_css, p_ccs, p_ssc;
  logic signed [SW-1:0] t_cb, t_sb;
  always_ff @(posedge clk) begin
    p_ccc <= SW'(rnd(PW'(ch) * PW'(cp), FRAC_BITS));  // ch*cp (times cb)
    p_sss <= SW'(rnd(PW'(sh) * PW'(sp), FRAC_BITS));  // sh*sp (times sb)
    p_csc <= SW'(rnd(PW'(ch) * PW'(sp), FRAC_BITS));  // ch*sp (times cb)
    p_scs <= SW'(rnd(PW'(sh) * PW'(cp), FRAC_BITS));  // sh*cp (times sb)
    t_cb  <= cb;
    t_sb  <= sb;
  end
  // Remaining pair products reuse the same four pairs with the other factor.
  always_comb begin
    p_scc = p_scs;  // sh*cp (times cb) for y
    p_css = p_csc;  // ch*sp (times sb) for y
    p_ccs = p_ccc;  // ch*cp (times sb) for z
    p_ssc = p_sss;  // sh*sp (times cb) for z
  end

  // Stage 3: triple products, exact.
  logic signed [PW-1:0] w1, w2, x1, x2, y1, y2, z1, z2;
  always_ff @(posedge clk) begin
    w1 <= p_ccc * t_cb;
    w2 <= p_sss * t_sb;
    x1 <= p_csc * t_cb;
    x2 <= p_scs * t_sb;
    y1 <= p_scc * t_cb;
    y2 <= p_css * t_sb;
    z1 <= p_ccs * t_sb;
    z2 <= p_ssc * t_cb;
  end

  function automatic logic signed [15:0] fin(input logic signed [PW:0] s, input logic neg);
    logic [PW:0] m;
    logic [PW:0] r;
    begin
      m = s[PW] ? (PW+1)'(-s) : (PW+1)'(s);
      if (RSH > 0) r = (m + ((PW+1)'(1) << (RSH - 1))) >> RSH;
      else r = m;
      if (r > (PW+1)'(OUT_ONE)) r = (PW+1)'(OUT_ONE);
      fin = (s[PW] ^ neg) ? -$signed(r[15:0]) : $signed(r[15:0]);
    end
  endfunction

  // Stage 4: sum or difference, round, saturate, conjugate.
  always_ff @(posedge clk) begin
    quat.quat_w <= fin((PW+1)'(w1) + (PW+1)'(w2), 1'b0);
    quat.quat_x <= fin((PW+1)'(x1) + (PW+1)'(x2), direction);
    quat.quat_y <= fin((PW+1)'(y1) - (PW+1)'(y2), direction);
    quat.quat_z <= fin((PW+1)'(z1) - (PW+1)'(z2), direction);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      direction <= 1'b0;
    end else begin
      valid <= {valid[2:0], start};
      if (cfg_we) begin
        direction <= cfg_data;
      end
    end
  end

  assign busy = 1'b0;
  assign done = valid[3];

endmodule

FILE: tb/e2q_checker.sv
// Checker for the Euler-angle to quaternion converter: predicts each quaternion
// word from the accepted angle words and compares. Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  e2q_pkg::angles_t angles,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             done,
  input  e2q_pkg::quat_t   quat,
  output int               fail_count,
  output int               pending
);
  import e2q_pkg::*;

  localparam int RB = 10;
  localparam int FB = 14;

  longint sin_tab [0:(1 << RB)];
  quat_t  quat_queue[$];
  logic   conj_mode;
  int     mismatches;

  // Builds the quarter-wave table with the same Taylor series in Q2.62.
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  initial begin
    logic [63:0] x, x2, sum, term, r;
    for (int k = 0; k <= (1 << RB); k++) begin
      x = q62_mul(64'h6487ED5110B4611A, 64'(k) << (62 - RB));
      x2 = q62_mul(x, x);
      sum = x;
      term = x;
      for (int n = 1; n < 61 && term != 0; n += 2) begin
        term = q62_mul(term, x2) / 64'((n + 1) * (n + 2));
        if (((n >> 1) & 1) == 0) sum = sum - term;
        else sum = sum + term;
      end
      r = (sum + (64'd1 << (61 - FB))) >> (62 - FB);
      if (r > (64'd1 << FB)) r = 64'd1 << FB;
      sin_tab[k] = longint'(r);
    end
  end

  function automatic void half_trig(input logic [15:0] a, output longint s,
                                    output longint c);
    int p, q, k;
    p = (int'(a) + (1 << (14 - RB))) >> (15 - RB);
    p &= (4 << RB) - 1;
    q = p >> RB;
    k = p & ((1 << RB) - 1);
    case (q)
      0: begin s = sin_tab[k]; c = sin_tab[(1 << RB) - k]; end
      1: begin s = sin_tab[(1 << RB) - k]; c = -sin_tab[k]; end
      2: begin s = -sin_tab[k]; c = -sin_tab[(1 << RB) - k]; end
      default: begin s = -sin_tab[(1 << RB) - k]; c = sin_tab[k]; end
    endcase
  endfunction

  function automatic longint round_away(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint prod3(input longint a, input longint b, input longint c);
    return round_away(a * b, FB) * c;
  endfunction

  function automatic logic [15:0] to_q14(input longint sum);
    longint r;
    r = round_away(sum, 2 * FB - 14);
    if (r > OUT_ONE) r = OUT_ONE;
    if (r < -OUT_ONE) r = -OUT_ONE;
    return r[15:0];
  endfunction

  function automatic quat_t rotation_of(input angles_t ang, input logic conj);
    longint sh, ch, sp, cp, sb, cb;
    quat_t q;
    half_trig(ang.heading_angle, sh, ch);
    half_trig(ang.pitch_angle, sp, cp);
    half_trig(ang.bank_angle, sb, cb);
    q.quat_w = to_q14(prod3(ch, cp, cb) + prod3(sh, sp, sb));
    q.quat_x = to_q14(prod3(ch, sp, cb) + prod3(sh, cp, sb));
    q.quat_y = to_q14(prod3(sh, cp, cb) - prod3(ch, sp, sb));
    q.quat_z = to_q14(prod3(ch, cp, sb) - prod3(sh, sp, cb));
    if (conj) begin
      q.quat_x = -q.quat_x;
      q.quat_y = -q.quat_y;
      q.quat_z = -q.quat_z;
    end
    return q;
  endfunction

  assign pending = quat_queue.size();

  always @(posedge clk) begin
    quat_t want;
    if (rst) begin
      conj_mode <= 1'b0;
      quat_queue.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (cfg_we) conj_mode <= cfg_data;
      if (done) begin
        if (quat_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches++ < 10) $display("unexpected quaternion word %h", quat);
        end else begin
          want = quat_queue.pop_front();
          if (want != quat) begin
            fail_count <= fail_count + 1;
            if (mismatches++ < 10)
              $display({"quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d, ",
                        "got w=%0d x=%0d y=%0d z=%0d"},
                       want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                       quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
          end
        end
      end
      if (start && !busy) quat_queue.push_back(rotation_of(angles, conj_mode));
    end
  end
endmodule

FILE: tb/testbench.sv
// Top of the testbench for euler_to_quaternion: clock, reset, angle stimulus,
// direction writes and the verdict. Depends on e2q_pkg and e2q_checker.
`timescale 1ns / 1ps
module testbench;
  import e2q_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  angles_t angles = '0;
  logic    cfg_we = 1'b0;
  logic    cfg_data = 1'b0;
  logic    done;
  quat_t   quat;
  int      fail_count;
  int      pending;
  int      idle_cycles;

  localparam int STALL_LIMIT = 2000;

  euler_to_quaternion dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angles(angles),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .quat(quat)
  );

  e2q_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angles(angles),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .quat(quat),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which neither an angle word nor a
  // quaternion word is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one angle word and holds it until accepted. Start stays high
  // when the next word follows at once; otherwise it is lowered before the
  // task returns.
  task automatic send_word(input angles_t a, input bit keep);
    start <= 1'b1;
    angles <= a;
    do @(posedge clk); while (busy);
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits for every expected word to come out of the pipeline.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_direction(input logic conj);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= conj;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_angle();
    // Quadrant boundaries and rounding ties in the table index are favored.
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 64)) - 16'd32;
      1: return 16'($urandom_range(0, 2047) << 5) + 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corner [0:7];
    angles_t a;
    int burst;
    corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h0010, 16'h000F,
               16'h7FF0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners of each angle in both directions, including ties.
    for (int d = 0; d < 2; d++) begin
      write_direction(d[0]);
      for (int i = 0; i < 8; i++) begin
        send_word('{corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]}, 1'b0);
      end
      send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
      send_word('{16'h2000, 16'h2000, 16'h2000}, 1'b0);
    end

    // Random bursts, writing the direction before each phase.
    for (int phase = 0; phase < 6; phase++) begin
      write_direction(phase == 5 ? 1'b1 : 1'($urandom_range(0, 1)));
      for (int n = 0; n < 100; n += burst) begin
        burst = $urandom_range(1, 20);
        for (int i = 0; i < burst; i++) begin
          a = '{pick_angle(), pick_angle(), pick_angle()};
          send_word(a, i != burst - 1);
        end
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/e2q_pkg.sv
rtl/core/e2q_sincos.sv
rtl/core/euler_to_quaternion.sv
tb/e2q_checker.sv
tb/testbench.sv
